FILE: src/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// constants, sigmoid table and saturating fixed-point helpers for the
// 2-2-2 backpropagation trainer
// ----------------------------------------------------------------------------
package mbt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SIG_DEPTH  = 256;
  localparam int SIG_IDX_W  = $clog2(SIG_DEPTH);
  localparam int TAB_W      = FRAC_BITS + 1;

  localparam int DATA_W     = 32;
  localparam int PIDX_W     = 4;
  localparam int TGT_W      = 17;
  localparam int OUT_W      = 17;
  localparam int BERR_W     = 31;
  localparam int LR_W       = 17;
  localparam int NUM_PARAMS = 12;

  localparam logic [LR_W-1:0]          LR_RESET = LR_W'(655);
  localparam logic signed [DATA_W-1:0] FX_ONE   = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] FX_1P5   = FX_ONE + (FX_ONE >>> 1);
  localparam logic signed [DATA_W-1:0] FX_MAX   = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] FX_MIN   = 32'sh8000_0000;

  localparam logic signed [DATA_W-1:0] BIAS_RST [4] = '{FX_ONE, FX_ONE, FX_1P5, FX_1P5};

  typedef logic [TAB_W-1:0] sig_tab_t [SIG_DEPTH+1];

  // restoring long division for table construction
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] dv);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, dv}) begin
        r    = r - {1'b0, dv};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t         tab;
    logic [63:0]      d;
    logic [63:0]      term;
    logic [63:0]      e;
    logic [63:0]      base;
    logic [63:0]      num;
    d    = udiv64(64'd8 << 32, 64'(SIG_DEPTH));
    term = 64'd1 << 32;
    base = term;
    e    = 64'd1 << 32;
    num  = 64'd1 << (FRAC_BITS + 32);
    for (int k = 1; k < 20; k++) begin
      term = udiv64((term * d) >> 32, 64'(k));
      if ((k & 1) != 0) base = base - term;
      else              base = base + term;
    end
    for (int i = 0; i <= SIG_DEPTH; i++) begin
      if (i > 0) e = (e * base) >> 32;
      tab[i] = TAB_W'(udiv64(num, (64'd1 << 32) + e));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [63:0] v);
    if (v > 64'(FX_MAX))      return FX_MAX;
    else if (v < 64'(FX_MIN)) return FX_MIN;
    else                      return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] fx_add(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? FX_MIN : FX_MAX;
    else                          return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] fx_sub(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) return s[DATA_W] ? FX_MIN : FX_MAX;
    else                          return s[DATA_W-1:0];
  endfunction

endpackage

FILE: src/mbt_ifs.sv
// ----------------------------------------------------------------------------
// mbt channel interfaces
// request channel and result channel of the trainer, valid/ready
// ----------------------------------------------------------------------------
interface mbt_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       action;
  logic [mbt_pkg::PIDX_W-1:0]                 param_index;
  logic signed [mbt_pkg::DATA_W-1:0]          param_value;
  logic signed [mbt_pkg::DATA_W-1:0]          sample_in_a;
  logic signed [mbt_pkg::DATA_W-1:0]          sample_in_b;
  logic [mbt_pkg::TGT_W-1:0]                  target_a;
  logic [mbt_pkg::TGT_W-1:0]                  target_b;
  logic                                       end_of_batch;

  modport source (output valid, action, param_index, param_value, sample_in_a,
                  sample_in_b, target_a, target_b, end_of_batch, input ready);
  modport sink   (input valid, action, param_index, param_value, sample_in_a,
                  sample_in_b, target_a, target_b, end_of_batch, output ready);
endinterface

interface mbt_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbt_pkg::OUT_W-1:0]   output_a;
  logic [mbt_pkg::OUT_W-1:0]   output_b;
  logic [mbt_pkg::OUT_W-1:0]   sample_error;
  logic [mbt_pkg::BERR_W-1:0]  batch_error;
  logic                        weights_updated;

  modport source (output valid, output_a, output_b, sample_error, batch_error,
                  weights_updated, input ready);
  modport sink   (input valid, output_a, output_b, sample_error, batch_error,
                  weights_updated, output ready);
endinterface

FILE: src/mlp_backprop_trainer_2_2_2.sv
// ----------------------------------------------------------------------------
// mlp_backprop_trainer_2_2_2
// 2-2-2 sigmoid network trainer, batch gradient descent in saturating Q16.16
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | contents
//  sample   | in  | valid/ready   | load or train request
//  result   | out | valid/ready   | outputs, sample error, batch error, update flag
//  cfg      | in  | write enable  | learning rate
//
//  a train request that closes a batch adds a parameter update pass; the one
//  shared 32x32 multiplier and the single read port of the parameter and
//  gradient memories set the order of the steps of each request.
//  a new request is taken while a finished result waits on the output register.
//  reset is synchronous; no clearing pass, biases and gradients carry valid bits.
module mlp_backprop_trainer_2_2_2 (
  input  logic                        clk,
  input  logic                        rst,
  mbt_in_if.sink                      sample,
  mbt_out_if.source                   result,
  input  logic                        cfg_write,
  input  logic [mbt_pkg::LR_W-1:0]    cfg_data
);
  import mbt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_TRAIN, S_UPDATE, S_DONE} state_t;

  localparam logic [5:0] TRAIN_LAST = 6'd36;
  localparam logic [5:0] UPD_LAST   = 6'(NUM_PARAMS + 1);
  localparam int         POS_SH     = SIG_IDX_W - 3;
  localparam int         POS_W      = DATA_W + 1 + POS_SH;
  localparam int         IDXF_W     = POS_W - FRAC_BITS;

  state_t state;
  logic [5:0] step;
  logic [LR_W-1:0] lr;

  logic signed [DATA_W-1:0] pm [NUM_PARAMS];
  logic signed [DATA_W-1:0] gm [NUM_PARAMS];
  logic signed [DATA_W-1:0] pm_q, gm_q;
  logic [PIDX_W-1:0] pm_qa, gm_qa;
  logic [3:0] bvalid;
  logic [NUM_PARAMS-1:0] gvalid;

  logic [PIDX_W-1:0] pm_ra, pm_wa, gm_ra, gm_wa;
  logic pm_we, gm_we;
  logic signed [DATA_W-1:0] pm_wd, gm_wd, pd, gd, fxp;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic signed [DATA_W-1:0] x0, x1, t0, t1, acc_a, acc_b, hid0, hid1, out0, out1;
  logic signed [DATA_W-1:0] dsh0, dsh1, ds0, ds1, dout0, dout1, dhid0, dhid1;
  logic signed [DATA_W-1:0] e0, err, eacc, pq;
  logic eob, upd;
  logic [BERR_W-1:0] berr;

  logic ov;
  logic [OUT_W-1:0] ro_a, ro_b, ro_se;
  logic [BERR_W-1:0] ro_be;
  logic ro_wu;

  // sigmoid unit
  logic sig_ld;
  logic signed [DATA_W-1:0] sig_in, sigy;
  logic [DATA_W:0] sg_ax;
  logic [POS_W-1:0] sg_pos;
  logic [IDXF_W-1:0] sg_idxf;
  logic [SIG_IDX_W:0] sg_idx;
  logic [TAB_W-1:0] sg_lo, sg_diff;
  logic [FRAC_BITS-1:0] sg_frac;
  logic sg_neg;
  logic [TAB_W+FRAC_BITS-1:0] sg_prod;
  logic [TAB_W-1:0] sg_s;

  function automatic logic signed [DATA_W-1:0] clamp_t(input logic [TGT_W-1:0] t);
    if (DATA_W'(t) > FX_ONE) return FX_ONE;
    else                     return DATA_W'(t);
  endfunction

  assign sg_ax   = sig_in[DATA_W-1] ? ((DATA_W+1)'(0) - {sig_in[DATA_W-1], sig_in})
                                    : {1'b0, sig_in};
  assign sg_pos  = {sg_ax, POS_SH'(0)};
  assign sg_idxf = sg_pos[POS_W-1:FRAC_BITS];
  assign sg_idx  = {1'b0, sg_idxf[SIG_IDX_W-1:0]};
  assign sg_prod = sg_diff * sg_frac;
  assign sg_s    = sg_lo + TAB_W'(sg_prod >> FRAC_BITS);
  assign sigy    = sg_neg ? (FX_ONE - DATA_W'(sg_s)) : DATA_W'(sg_s);

  always_ff @(posedge clk) begin
    if (sig_ld) begin
      sg_neg <= sig_in[DATA_W-1];
      if (sg_idxf >= IDXF_W'(SIG_DEPTH)) begin
        sg_lo   <= SIG_TAB[SIG_DEPTH];
        sg_diff <= '0;
        sg_frac <= '0;
      end else begin
        sg_lo   <= SIG_TAB[sg_idx];
        sg_diff <= SIG_TAB[sg_idx + 1'b1] - SIG_TAB[sg_idx];
        sg_frac <= sg_pos[FRAC_BITS-1:0];
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (pm_we) pm[pm_wa] <= pm_wd;
    pm_q  <= pm[pm_ra];
    pm_qa <= pm_ra;
  end

  always_ff @(posedge clk) begin
    if (gm_we) gm[gm_wa] <= gm_wd;
    gm_q  <= gm[gm_ra];
    gm_qa <= gm_ra;
  end

  assign pd = (pm_qa[3] && !bvalid[pm_qa[1:0]]) ? BIAS_RST[pm_qa[1:0]] : pm_q;
  assign gd = gvalid[gm_qa] ? gm_q : '0;

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign fxp = sat_wide(prod >>> FRAC_BITS);

  always_comb begin
    pm_ra  = '0;
    gm_ra  = '0;
    pm_we  = 1'b0;
    pm_wa  = '0;
    pm_wd  = '0;
    gm_we  = 1'b0;
    gm_wa  = '0;
    gm_wd  = '0;
    mul_a  = '0;
    mul_b  = '0;
    sig_ld = 1'b0;
    sig_in = acc_a;
    case (state)
      S_IDLE: begin
        if (sample.valid && !sample.action &&
            sample.param_index < PIDX_W'(NUM_PARAMS)) begin
          pm_we = 1'b1;
          pm_wa = sample.param_index;
          pm_wd = sample.param_value;
        end
      end
      S_TRAIN: begin
        case (step)
          6'd0:  pm_ra = 4'd8;
          6'd1:  pm_ra = 4'd0;
          6'd2:  begin pm_ra = 4'd1; mul_a = pd; mul_b = x0; end
          6'd3:  begin pm_ra = 4'd9; mul_a = pd; mul_b = x1; end
          6'd4:  pm_ra = 4'd2;
          6'd5:  begin pm_ra = 4'd3; mul_a = pd; mul_b = x0; sig_ld = 1'b1; end
          6'd6:  begin mul_a = pd; mul_b = x1; end
          6'd7:  pm_ra = 4'd10;
          6'd8:  begin pm_ra = 4'd4; sig_ld = 1'b1; sig_in = acc_b; end
          6'd9:  begin pm_ra = 4'd5; mul_a = pd; mul_b = hid0; end
          6'd10: begin pm_ra = 4'd11; mul_a = pd; mul_b = hid1; end
          6'd11: begin pm_ra = 4'd6; mul_a = hid0; mul_b = FX_ONE - hid0; end
          6'd12: begin pm_ra = 4'd7; mul_a = pd; mul_b = hid0; sig_ld = 1'b1; end
          6'd13: begin mul_a = pd; mul_b = hid1; end
          6'd14: begin mul_a = hid1; mul_b = FX_ONE - hid1; end
          6'd15: begin
            sig_ld = 1'b1;
            sig_in = acc_b;
            mul_a  = t0 - out0;
            mul_b  = t0 - out0;
          end
          6'd16: begin mul_a = out0; mul_b = FX_ONE - out0; end
          6'd17: begin mul_a = out1; mul_b = FX_ONE - out1; end
          6'd18: begin mul_a = t1 - out1; mul_b = t1 - out1; end
          6'd19: begin mul_a = out0 - t0; mul_b = ds0; end
          6'd20: begin mul_a = out1 - t1; mul_b = ds1; gm_ra = 4'd10; end
          6'd21: begin
            gm_we = 1'b1; gm_wa = 4'd10; gm_wd = fx_add(gd, dout0);
            mul_a = dout0; mul_b = hid0; gm_ra = 4'd4;
          end
          6'd22: begin
            gm_we = 1'b1; gm_wa = 4'd4; gm_wd = fx_add(gd, fxp);
            mul_a = dout0; mul_b = hid1; gm_ra = 4'd5;
          end
          6'd23: begin
            gm_we = 1'b1; gm_wa = 4'd5; gm_wd = fx_add(gd, fxp);
            mul_a = dout1; mul_b = hid0; gm_ra = 4'd6;
          end
          6'd24: begin
            gm_we = 1'b1; gm_wa = 4'd6; gm_wd = fx_add(gd, fxp);
            mul_a = dout1; mul_b = hid1; gm_ra = 4'd7; pm_ra = 4'd4;
          end
          6'd25: begin
            gm_we = 1'b1; gm_wa = 4'd7; gm_wd = fx_add(gd, fxp);
            mul_a = dout0; mul_b = pd; gm_ra = 4'd11; pm_ra = 4'd6;
          end
          6'd26: begin
            gm_we = 1'b1; gm_wa = 4'd11; gm_wd = fx_add(gd, dout1);
            mul_a = dout1; mul_b = pd; pm_ra = 4'd5;
          end
          6'd27: begin mul_a = dout0; mul_b = pd; pm_ra = 4'd7; end
          6'd28: begin mul_a = dout1; mul_b = pd; end
          6'd29: begin mul_a = acc_a; mul_b = dsh0; end
          6'd30: begin mul_a = acc_b; mul_b = dsh1; gm_ra = 4'd8; end
          6'd31: begin
            gm_we = 1'b1; gm_wa = 4'd8; gm_wd = fx_add(gd, dhid0);
            mul_a = dhid0; mul_b = x0; gm_ra = 4'd0;
          end
          6'd32: begin
            gm_we = 1'b1; gm_wa = 4'd0; gm_wd = fx_add(gd, fxp);
            mul_a = dhid0; mul_b = x1; gm_ra = 4'd1;
          end
          6'd33: begin
            gm_we = 1'b1; gm_wa = 4'd1; gm_wd = fx_add(gd, fxp);
            mul_a = dhid1; mul_b = x0; gm_ra = 4'd2;
          end
          6'd34: begin
            gm_we = 1'b1; gm_wa = 4'd2; gm_wd = fx_add(gd, fxp);
            mul_a = dhid1; mul_b = x1; gm_ra = 4'd3;
          end
          6'd35: begin
            gm_we = 1'b1; gm_wa = 4'd3; gm_wd = fx_add(gd, fxp);
            gm_ra = 4'd9;
          end
          6'd36: begin
            gm_we = 1'b1; gm_wa = 4'd9; gm_wd = fx_add(gd, dhid1);
          end
          default: ;
        endcase
      end
      S_UPDATE: begin
        if (step < 6'(NUM_PARAMS)) begin
          pm_ra = step[PIDX_W-1:0];
          gm_ra = step[PIDX_W-1:0];
        end
        if (step >= 6'd1 && step <= 6'(NUM_PARAMS)) begin
          mul_a = DATA_W'(lr);
          mul_b = gd;
        end
        if (step >= 6'd2) begin
          pm_we = 1'b1;
          pm_wa = PIDX_W'(step - 6'd2);
          pm_wd = fx_sub(pq, fxp);
        end
      end
      default: ;
    endcase
  end

  assign sample.ready           = (state == S_IDLE);
  assign result.valid           = ov;
  assign result.output_a        = ro_a;
  assign result.output_b        = ro_b;
  assign result.sample_error    = ro_se;
  assign result.batch_error     = ro_be;
  assign result.weights_updated = ro_wu;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      lr     <= LR_RESET;
      bvalid <= '0;
      gvalid <= '0;
      eacc   <= '0;
      ov     <= 1'b0;
    end else begin
      if (cfg_write) lr <= cfg_data;
      if (pm_we && pm_wa[3]) bvalid[pm_wa[1:0]] <= 1'b1;
      if (gm_we) gvalid[gm_wa] <= 1'b1;
      if (state == S_DONE && (!ov || result.ready)) ov <= 1'b1;
      else if (result.ready)                       ov <= 1'b0;
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            x0   <= sample.sample_in_a;
            x1   <= sample.sample_in_b;
            t0   <= clamp_t(sample.target_a);
            t1   <= clamp_t(sample.target_b);
            eob  <= sample.end_of_batch;
            step <= '0;
            if (sample.action) begin
              state <= S_TRAIN;
            end else begin
              out0  <= '0;
              out1  <= '0;
              err   <= '0;
              berr  <= '0;
              upd   <= 1'b0;
              state <= S_DONE;
            end
          end
        end
        S_TRAIN: begin
          step <= (step == TRAIN_LAST) ? 6'd0 : step + 6'd1;
          case (step)
            6'd1:  acc_a <= pd;
            6'd3:  acc_a <= fx_add(acc_a, fxp);
            6'd4:  begin acc_a <= fx_add(acc_a, fxp); acc_b <= pd; end
            6'd6:  begin hid0 <= sigy; acc_b <= fx_add(acc_b, fxp); end
            6'd7:  acc_b <= fx_add(acc_b, fxp);
            6'd8:  acc_a <= pd;
            6'd9:  hid1 <= sigy;
            6'd10: acc_a <= fx_add(acc_a, fxp);
            6'd11: begin acc_a <= fx_add(acc_a, fxp); acc_b <= pd; end
            6'd12: dsh0 <= fxp;
            6'd13: begin out0 <= sigy; acc_b <= fx_add(acc_b, fxp); end
            6'd14: acc_b <= fx_add(acc_b, fxp);
            6'd15: dsh1 <= fxp;
            6'd16: begin out1 <= sigy; e0 <= fxp >>> 1; end
            6'd17: ds0 <= fxp;
            6'd18: ds1 <= fxp;
            6'd19: err <= e0 + (fxp >>> 1);
            6'd20: dout0 <= fxp;
            6'd21: begin dout1 <= fxp; eacc <= fx_add(eacc, err); end
            6'd26: acc_a <= fxp;
            6'd27: acc_a <= fx_add(acc_a, fxp);
            6'd28: acc_b <= fxp;
            6'd29: acc_b <= fx_add(acc_b, fxp);
            6'd30: dhid0 <= fxp;
            6'd31: dhid1 <= fxp;
            TRAIN_LAST: begin
              upd  <= eob;
              berr <= eob ? eacc[BERR_W-1:0] : '0;
              if (eob) begin
                eacc  <= '0;
                state <= S_UPDATE;
              end else begin
                state <= S_DONE;
              end
            end
            default: ;
          endcase
        end
        S_UPDATE: begin
          step <= step + 6'd1;
          pq   <= pd;
          if (step == UPD_LAST) begin
            gvalid <= '0;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov || result.ready) begin
            ro_a  <= out0[OUT_W-1:0];
            ro_b  <= out1[OUT_W-1:0];
            ro_se <= err[OUT_W-1:0];
            ro_be <= berr;
            ro_wu <= upd;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: verif/mbt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mbt_checker
// watches the request and result channels of the 2-2-2 trainer, predicts
// every result in saturating Q16.16 and compares it field by field
// ----------------------------------------------------------------------------
module mbt_checker (
  input  logic                     clk,
  input  logic                     rst,
  mbt_in_if                        sample,
  mbt_out_if                       result,
  input  logic                     cfg_write,
  input  logic [mbt_pkg::LR_W-1:0] cfg_data,
  output int                       fail_count,
  output int                       pending_results,
  output int                       trains_seen,
  output int                       updates_seen
);
  import mbt_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0]  out_a;
    logic [OUT_W-1:0]  out_b;
    logic [OUT_W-1:0]  serr;
    logic [BERR_W-1:0] berr;
    logic              upd;
  } trainer_result_t;

  localparam logic signed [63:0] ONE64 = 64'sd1 << FRAC_BITS;

  trainer_result_t   expected_results [$];
  logic [LR_W-1:0]   step_size;
  logic signed [31:0] weights [8];
  logic signed [31:0] biases [4];
  logic signed [31:0] grads [12];
  logic signed [31:0] err_sum;
  longint            sig_points [SIG_DEPTH+1];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7fffffff) return 32'sh7fffffff;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  function automatic void make_sigmoid_points();
    logic [63:0] d, term, base, e;
    d = (64'd8 << 32) / SIG_DEPTH;
    term = 64'd1 << 32;
    base = term;
    e = 64'd1 << 32;
    for (int k = 1; k < 20; k++) begin
      term = ((term * d) >> 32) / 64'(k);
      if (k & 1) base = base - term;
      else base = base + term;
    end
    for (int i = 0; i <= SIG_DEPTH; i++) begin
      if (i > 0) e = (e * base) >> 32;
      sig_points[i] = longint'((64'd1 << (FRAC_BITS + 32)) / ((64'd1 << 32) + e));
    end
  endfunction

  function automatic logic signed [31:0] squash(logic signed [31:0] x);
    longint ax, pos, idx, frac, s;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    pos = (ax * SIG_DEPTH) >> 3;
    idx = pos >> FRAC_BITS;
    frac = pos & (ONE64 - 1);
    if (idx >= SIG_DEPTH) s = sig_points[SIG_DEPTH];
    else s = sig_points[idx] + (((sig_points[idx+1] - sig_points[idx]) * frac) >>> FRAC_BITS);
    if (x < 0) s = ONE64 - s;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] squash_slope(logic signed [31:0] y);
    return qmul(y, qsub(ONE64[31:0], y));
  endfunction

  function automatic void reset_network();
    step_size = LR_RESET;
    foreach (weights[i]) weights[i] = '0;
    foreach (biases[i]) biases[i] = BIAS_RST[i];
    foreach (grads[i]) grads[i] = '0;
    err_sum = '0;
  endfunction

  function automatic trainer_result_t train_or_load(logic act, logic [3:0] pidx,
      logic signed [31:0] pval, logic signed [31:0] xa, logic signed [31:0] xb,
      logic [16:0] ta, logic [16:0] tb, logic eob);
    trainer_result_t r;
    logic signed [31:0] x [2], tgt [2], hid [2], outv [2], dout [2], net, acc, diff, serr;
    int k;
    r = '0;
    if (!act) begin
      if (pidx < 8) weights[pidx] = pval;
      else if (pidx < 12) biases[pidx-8] = pval;
      return r;
    end
    x[0] = xa; x[1] = xb;
    tgt[0] = (ta > 17'd65536) ? 32'sd65536 : 32'(ta);
    tgt[1] = (tb > 17'd65536) ? 32'sd65536 : 32'(tb);
    serr = '0;
    for (int h = 0; h < 2; h++) begin
      net = biases[h];
      for (int i = 0; i < 2; i++) net = qadd(net, qmul(weights[i+2*h], x[i]));
      hid[h] = squash(net);
    end
    for (int o = 0; o < 2; o++) begin
      net = biases[2+o];
      for (int h = 0; h < 2; h++) net = qadd(net, qmul(weights[4+2*o+h], hid[h]));
      outv[o] = squash(net);
      diff = tgt[o] - outv[o];
      serr = serr + (qmul(diff, diff) >>> 1);
    end
    for (int o = 0; o < 2; o++) begin
      dout[o] = qmul(outv[o] - tgt[o], squash_slope(outv[o]));
      for (int h = 0; h < 2; h++) begin
        k = 4 + 2*o + h;
        grads[k] = qadd(grads[k], qmul(dout[o], hid[h]));
      end
      grads[10+o] = qadd(grads[10+o], dout[o]);
    end
    for (int h = 0; h < 2; h++) begin
      acc = '0;
      for (int o = 0; o < 2; o++) acc = qadd(acc, qmul(dout[o], weights[4+2*o+h]));
      acc = qmul(acc, squash_slope(hid[h]));
      for (int i = 0; i < 2; i++) grads[i+2*h] = qadd(grads[i+2*h], qmul(acc, x[i]));
      grads[8+h] = qadd(grads[8+h], acc);
    end
    err_sum = qadd(err_sum, serr);
    if (eob) begin
      for (int i = 0; i < 8; i++) weights[i] = qsub(weights[i], qmul(32'(step_size), grads[i]));
      for (int i = 0; i < 4; i++) biases[i] = qsub(biases[i], qmul(32'(step_size), grads[8+i]));
      foreach (grads[i]) grads[i] = '0;
      r.berr = err_sum[30:0];
      err_sum = '0;
      r.upd = 1'b1;
    end
    r.out_a = outv[0][16:0];
    r.out_b = outv[1][16:0];
    r.serr = serr[16:0];
    return r;
  endfunction

  initial make_sigmoid_points();

  always @(posedge clk) begin
    trainer_result_t got, want;
    if (rst) begin
      reset_network();
      expected_results.delete();
      fail_count <= 0;
      trains_seen <= 0;
      updates_seen <= 0;
    end else begin
      if (cfg_write) step_size = cfg_data;
      if (sample.valid && sample.ready) begin
        expected_results.push_back(train_or_load(sample.action, sample.param_index,
          sample.param_value, sample.sample_in_a, sample.sample_in_b,
          sample.target_a, sample.target_b, sample.end_of_batch));
        if (sample.action) trains_seen <= trains_seen + 1;
        if (sample.action && sample.end_of_batch) updates_seen <= updates_seen + 1;
      end
      if (result.valid && result.ready) begin
        got = '{result.output_a, result.output_b, result.sample_error,
                result.batch_error, result.weights_updated};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_results <= expected_results.size();
  end
endmodule

FILE: verif/tb_mlp_backprop_trainer_2_2_2.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mlp_backprop_trainer_2_2_2
// loads weights and trains the 2-2-2 network through directed and random
// batches under bursty requests, result stalls and learning-rate changes
// ----------------------------------------------------------------------------
module tb_mlp_backprop_trainer_2_2_2;
  import mbt_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [LR_W-1:0] cfg_data;
  int fail_count, pending_results, trains_seen, updates_seen;
  int idle_cycles;
  int sent;
  bit hold_off;

  mbt_in_if  sample ();
  mbt_out_if result ();

  mlp_backprop_trainer_2_2_2 u_top (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  mbt_checker u_checker (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .cfg_write(cfg_write), .cfg_data(cfg_data), .fail_count(fail_count),
    .pending_results(pending_results), .trains_seen(trains_seen),
    .updates_seen(updates_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    sample.valid = 1'b0;
    sample.action = 1'b0;
    sample.param_index = '0;
    sample.param_value = '0;
    sample.sample_in_a = '0;
    sample.sample_in_b = '0;
    sample.target_a = '0;
    sample.target_b = '0;
    sample.end_of_batch = 1'b0;
    result.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    rst = 1'b1;
  end

  // result stalls on a pattern of their own, with one long hold-off
  initial begin
    int mode;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        result.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        if (mode == 0) result.ready <= 1'b1;
        else result.ready <= ($urandom_range(0, 3) >= mode);
        @(posedge clk);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if ((sample.valid && sample.ready) || (result.valid && result.ready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", pending_results);
        $display("FAIL");
        $finish;
      end
    end
  end

  int burst_left;

  task automatic send_request(logic act, logic [3:0] pidx, logic signed [31:0] pval,
      logic signed [31:0] xa, logic signed [31:0] xb, logic [16:0] ta, logic [16:0] tb,
      logic eob);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        sample.valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    sample.valid <= 1'b1;
    sample.action <= act;
    sample.param_index <= pidx;
    sample.param_value <= pval;
    sample.sample_in_a <= xa;
    sample.sample_in_b <= xb;
    sample.target_a <= ta;
    sample.target_b <= tb;
    sample.end_of_batch <= eob;
    @(posedge clk iff sample.ready);
    sent++;
  endtask

  task automatic load_param(logic [3:0] pidx, logic signed [31:0] pval);
    send_request(1'b0, pidx, pval, $urandom, $urandom, 17'($urandom), 17'($urandom),
                 1'($urandom));
  endtask

  task automatic train_sample(logic signed [31:0] xa, logic signed [31:0] xb,
      logic [16:0] ta, logic [16:0] tb, logic eob);
    send_request(1'b1, 4'($urandom), $urandom, xa, xb, ta, tb, eob);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic logic [16:0] rand_target();
    if ($urandom_range(0, 9) == 0) return 17'($urandom);
    return 17'($urandom_range(0, 65536));
  endfunction

  task automatic drain_and_set_rate(logic [LR_W-1:0] rate);
    sample.valid <= 1'b0;
    @(posedge clk iff pending_results == 0);
    repeat (60) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= rate;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int batch_len;
    burst_left = 0;
    sent = 0;
    hold_off = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all parameters, unused indices, extremes of inputs and targets
    for (int i = 0; i < 12; i++) load_param(4'(i), $signed(32'(i * 9000)) - 32'sd40000);
    load_param(4'd12, 32'sh7fffffff);
    load_param(4'd15, 32'sh80000000);
    train_sample(32'sh7fffffff, 32'sh80000000, 17'd65536, 17'd0, 1'b0);
    train_sample(32'sh80000000, 32'sh7fffffff, 17'h1ffff, 17'h1ffff, 1'b0);
    train_sample(32'sd0, 32'sd0, 17'd0, 17'd65536, 1'b1);
    train_sample(32'sd65536, -32'sd65536, 17'd32768, 17'd32768, 1'b1);
    drain_and_set_rate(17'd65536);
    train_sample(32'sh7fffffff, 32'sh7fffffff, 17'd0, 17'd0, 1'b1);
    load_param(4'd4, 32'sh7fffffff);
    load_param(4'd9, 32'sh80000000);
    train_sample(32'sd100, -32'sd100, 17'd65536, 17'd65536, 1'b1);
    drain_and_set_rate(17'd0);
    train_sample(32'sd131072, 32'sd0, 17'd1000, 17'd60000, 1'b1);

    // random batches
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) hold_off = 1;
      while (sent < 220 * (phase + 1)) begin
        if ($urandom_range(0, 7) == 0)
          for (int j = $urandom_range(1, 4); j > 0; j--)
            load_param(4'($urandom_range(0, 15)), rand_value());
        batch_len = $urandom_range(1, 8);
        for (int j = 1; j <= batch_len; j++)
          train_sample(rand_value(), rand_value(), rand_target(), rand_target(),
                       j == batch_len);
      end
      case (phase)
        0: drain_and_set_rate(17'd655);
        1: drain_and_set_rate(17'd65536);
        2: drain_and_set_rate(17'd1);
        3: drain_and_set_rate(17'($urandom_range(0, 65536)));
        default: drain_and_set_rate(17'd0);
      endcase
    end

    sample.valid <= 1'b0;
    @(posedge clk iff pending_results == 0);
    repeat (60) @(posedge clk);
    $display("%0d requests, %0d training samples, %0d batch updates, several rates",
             sent, trains_seen, updates_seen);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
